>>> rtl/hbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// hbd_pkg: shared types and constants for the bus decoder with mbc1 bank control
// no dependencies; imported by every module of the block

package hbd_pkg;

  // rom bank register width, default and widest supported value
  localparam int ROM_BANK_BITS_DEF = 7;
  localparam int ROM_BANK_MAX_W    = 7;

  localparam int ADDR_W   = 16;
  localparam int DATA_W   = 8;
  localparam int OFFSET_W = 21;
  localparam int REGION_W = 4;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_CART_KIND    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOT_OVERLAY = 1'd1;

  // cartridge kinds
  localparam logic [1:0] CART_NONE          = 2'd0;
  localparam logic [1:0] CART_MBC1          = 2'd1;
  localparam logic [1:0] CART_MBC1_RAM      = 2'd2;
  localparam logic [1:0] CART_MBC1_RAM_BATT = 2'd3;

  // access direction
  localparam logic FUNC_READ  = 1'b0;
  localparam logic FUNC_WRITE = 1'b1;

  // controller register select, address bits 14:13
  localparam logic [1:0] SEL_RAM_EN = 2'd0;
  localparam logic [1:0] SEL_ROM_LO = 2'd1;
  localparam logic [1:0] SEL_ROM_HI = 2'd2;
  localparam logic [1:0] SEL_MODE   = 2'd3;

  localparam logic [DATA_W-1:0] RAM_EN_KEY = 8'h0A;

  // region codes
  localparam logic [REGION_W-1:0] REGION_BOOT   = 4'd0;
  localparam logic [REGION_W-1:0] REGION_ICON   = 4'd1;
  localparam logic [REGION_W-1:0] REGION_LOGO   = 4'd2;
  localparam logic [REGION_W-1:0] REGION_ROM    = 4'd3;
  localparam logic [REGION_W-1:0] REGION_VRAM   = 4'd4;
  localparam logic [REGION_W-1:0] REGION_EXTRAM = 4'd5;
  localparam logic [REGION_W-1:0] REGION_WRAM   = 4'd6;
  localparam logic [REGION_W-1:0] REGION_OAM    = 4'd7;
  localparam logic [REGION_W-1:0] REGION_HRAM   = 4'd8;
  localparam logic [REGION_W-1:0] REGION_IE     = 4'd9;
  localparam logic [REGION_W-1:0] REGION_IO     = 4'd10;
  localparam logic [REGION_W-1:0] REGION_NONE   = 4'd11;
  localparam logic [REGION_W-1:0] REGION_MBC    = 4'd12;

  // one bus access
  typedef struct packed {
    logic              func;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } access_t;

  // one decoded result
  typedef struct packed {
    logic [REGION_W-1:0]       region;
    logic [OFFSET_W-1:0]       phys_offset;
    logic                      ram_enabled;
    logic [ROM_BANK_MAX_W-1:0] current_rom_bank;
    logic [1:0]                current_ram_bank;
  } result_t;

  // bank controller state, rom bank zero extended to the widest form
  typedef struct packed {
    logic                      ram_enable;
    logic [ROM_BANK_MAX_W-1:0] rom_bank;
    logic [1:0]                ram_bank;
    logic                      mode;
  } mbc_state_t;

endpackage

`default_nettype wire

>>> rtl/hbd_mbc.sv
`timescale 1ns / 1ps
`default_nettype none
// hbd_mbc: mbc1 bank controller registers and their write decode
// depends on hbd_pkg

module hbd_mbc import hbd_pkg::*; #(
  parameter int ROM_BANK_BITS = ROM_BANK_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  logic [1:0]        sel,
  input  logic [DATA_W-1:0] wr_data,
  input  logic [1:0]        cart_kind,
  output mbc_state_t        state,
  output mbc_state_t        state_next
);

  logic [ROM_BANK_BITS-1:0]  rom_bank;
  logic [ROM_BANK_BITS-1:0]  rom_bank_next;
  logic [1:0]                ram_bank;
  logic [1:0]                ram_bank_next;
  logic                      ram_enable;
  logic                      ram_enable_next;
  logic                      mode;
  logic                      mode_next;
  logic [ROM_BANK_MAX_W-1:0] rom_wide;
  logic [ROM_BANK_MAX_W-1:0] rom_tmp;
  logic [4:0]                low5;

  assign rom_wide = ROM_BANK_MAX_W'(rom_bank);
  // bank 0 in the low field selects bank 1
  assign low5 = (wr_data[4:0] == 5'd0) ? 5'd1 : wr_data[4:0];

  always_comb begin
    rom_tmp         = rom_wide;
    ram_bank_next   = ram_bank;
    ram_enable_next = ram_enable;
    mode_next       = mode;
    if (wr_en && (cart_kind != CART_NONE)) begin
      case (sel)
        SEL_RAM_EN: begin
          ram_enable_next = (wr_data == RAM_EN_KEY);
        end
        SEL_ROM_LO: begin
          rom_tmp = {rom_wide[6:5], low5};
        end
        SEL_ROM_HI: begin
          if (mode) begin
            ram_bank_next = wr_data[1:0];
          end else begin
            rom_tmp = {wr_data[1:0], rom_wide[4:0]};
          end
        end
        SEL_MODE: begin
          if ((cart_kind == CART_MBC1_RAM) || (cart_kind == CART_MBC1_RAM_BATT)) begin
            mode_next = wr_data[0];
          end
        end
        default: begin
          rom_tmp = rom_wide;
        end
      endcase
    end
    rom_bank_next = rom_tmp[ROM_BANK_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank   <= ROM_BANK_BITS'(1);
      ram_bank   <= 2'd0;
      ram_enable <= 1'b0;
      mode       <= 1'b0;
    end else begin
      rom_bank   <= rom_bank_next;
      ram_bank   <= ram_bank_next;
      ram_enable <= ram_enable_next;
      mode       <= mode_next;
    end
  end

  assign state.ram_enable      = ram_enable;
  assign state.rom_bank        = rom_wide;
  assign state.ram_bank        = ram_bank;
  assign state.mode            = mode;
  assign state_next.ram_enable = ram_enable_next;
  assign state_next.rom_bank   = ROM_BANK_MAX_W'(rom_bank_next);
  assign state_next.ram_bank   = ram_bank_next;
  assign state_next.mode       = mode_next;

endmodule

`default_nettype wire

>>> rtl/hbd_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// hbd_decode: address map decode to region and banked offset
// depends on hbd_pkg

module hbd_decode import hbd_pkg::*; (
  input  logic [ADDR_W-1:0]   address,
  input  logic                overlay,
  input  mbc_state_t          state,
  output logic [REGION_W-1:0] region,
  output logic [OFFSET_W-1:0] phys_offset
);

  logic [7:0] logo_off;

  assign logo_off = address[7:0] - 8'h04;

  always_comb begin
    region      = REGION_NONE;
    phys_offset = '0;
    if (address[15:14] == 2'b00) begin
      if (overlay && (address[15:8] == 8'h00)) begin
        if (address[7:3] == 5'b11011) begin
          region      = REGION_ICON;
          phys_offset = OFFSET_W'(address[2:0]);
        end else begin
          region      = REGION_BOOT;
          phys_offset = OFFSET_W'(address);
        end
      end else if (overlay && (address >= 16'h0104) && (address <= 16'h0133)) begin
        region      = REGION_LOGO;
        phys_offset = OFFSET_W'(logo_off);
      end else begin
        region      = REGION_ROM;
        phys_offset = OFFSET_W'(address);
      end
    end else if (address[15:14] == 2'b01) begin
      // switched bank window
      region      = REGION_ROM;
      phys_offset = {state.rom_bank, address[13:0]};
    end else if (address[15:13] == 3'b100) begin
      region      = REGION_VRAM;
      phys_offset = OFFSET_W'(address[12:0]);
    end else if (address[15:13] == 3'b101) begin
      region      = REGION_EXTRAM;
      phys_offset = OFFSET_W'({state.ram_bank, address[12:0]});
    end else if (address < 16'hFE00) begin
      region      = REGION_WRAM;
      phys_offset = OFFSET_W'(address[12:0]);
    end else if (address < 16'hFEA0) begin
      region      = REGION_OAM;
      phys_offset = OFFSET_W'(address[7:0]);
    end else if (address < 16'hFF00) begin
      region      = REGION_NONE;
    end else if (address == 16'hFFFF) begin
      region      = REGION_IE;
    end else if (address >= 16'hFF80) begin
      region      = REGION_HRAM;
      phys_offset = OFFSET_W'(address[6:0]);
    end else begin
      region      = REGION_IO;
      phys_offset = OFFSET_W'(address[7:0]);
    end
  end

endmodule

`default_nettype wire

>>> rtl/handheld_bus_decoder_mbc1.sv
`timescale 1ns / 1ps
`default_nettype none
// handheld_bus_decoder_mbc1: top level, bus access decode with mbc1 bank control
// depends on hbd_pkg, hbd_mbc, hbd_decode
//
// channel   direction  handshake              beat
// access    in         access_valid / stall   func, address, write_data
// result    out        result_valid / stall   region, offset, bank status
// cfg       in         cfg_valid / cfg_ready  register index, write data
//
// one beat per clock sustained while not stalled (access register, result register)
// the throughput is set by the single decode pass between the two registers
// bank registers update on the edge that loads the matching result beat
// rst (synchronous) clears both valid flags, config and the bank registers (rom bank 1)
// a stalled result holds; access keeps flowing until the access register is also full

module handheld_bus_decoder_mbc1 import hbd_pkg::*; #(
  parameter int ROM_BANK_BITS = ROM_BANK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  access_valid,
  output logic                  access_stall,
  input  access_t               access,
  output logic                  result_valid,
  input  logic                  result_stall,
  output result_t               result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  logic [1:0] cart_kind;
  logic       boot_overlay;

  // access register
  logic    acc_valid;
  access_t acc;

  // pipeline control
  logic result_load;
  logic acc_take;
  logic is_mbc_wr;
  logic mbc_wr_en;

  mbc_state_t          mbc_state;
  mbc_state_t          mbc_state_next;
  logic [REGION_W-1:0] dec_region;
  logic [OFFSET_W-1:0] dec_offset;
  result_t             result_next;

  // config writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cart_kind    <= CART_NONE;
      boot_overlay <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_CART_KIND:    cart_kind    <= cfg_data[1:0];
        CFG_BOOT_OVERLAY: boot_overlay <= cfg_data[0];
        default:          cart_kind    <= cart_kind;
      endcase
    end
  end

  // result register loads when empty or being drained
  assign result_load  = !result_valid || !result_stall;
  // access register frees when its beat moves on
  assign access_stall = acc_valid && !result_load;
  assign acc_take     = access_valid && !access_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else if (acc_take) begin
      acc_valid <= 1'b1;
    end else if (result_load) begin
      acc_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_take) begin
      acc <= access;
    end
  end

  // writes below 0x8000 go to the bank controller
  assign is_mbc_wr = (acc.func == FUNC_WRITE) && !acc.address[15];
  assign mbc_wr_en = acc_valid && result_load && is_mbc_wr;

  hbd_mbc #(
    .ROM_BANK_BITS(ROM_BANK_BITS)
  ) u_mbc (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (mbc_wr_en),
    .sel        (acc.address[14:13]),
    .wr_data    (acc.write_data),
    .cart_kind  (cart_kind),
    .state      (mbc_state),
    .state_next (mbc_state_next)
  );

  // boot overlay only applies to reads
  hbd_decode u_decode (
    .address     (acc.address),
    .overlay     ((acc.func == FUNC_READ) && boot_overlay),
    .state       (mbc_state),
    .region      (dec_region),
    .phys_offset (dec_offset)
  );

  always_comb begin
    result_next.region           = is_mbc_wr ? REGION_MBC : dec_region;
    result_next.phys_offset      = is_mbc_wr ? OFFSET_W'(acc.address) : dec_offset;
    // status fields show the controller after this access
    result_next.ram_enabled      = mbc_state_next.ram_enable;
    result_next.current_rom_bank = mbc_state_next.rom_bank;
    result_next.current_ram_bank = mbc_state_next.ram_bank;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= acc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load && acc_valid) begin
      result <= result_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// hbd_checker: port level checks for the bus decoder, bound to the top level
// depends on hbd_pkg and handheld_bus_decoder_mbc1

module hbd_checker import hbd_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // nothing comes out the cycle after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result beat right after reset");

  // controller writes report an address below 0x8000
  a_mbc_offset: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.region == REGION_MBC)) |-> (result.phys_offset[20:15] == 6'd0))
    else $error("controller write offset out of range");

  // low rom bank field never reads as zero
  a_bank_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.current_rom_bank[4:0] != 5'd0))
    else $error("rom bank low field is zero");

  // unusable area reports offset zero
  a_none_offset: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (result.region == REGION_NONE)) |-> (result.phys_offset == '0))
    else $error("unusable area with nonzero offset");

  // a stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result beat changed");

endmodule

bind handheld_bus_decoder_mbc1 hbd_checker u_hbd_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire

>>> tb/tb_handheld_bus_decoder_mbc1.sv
`timescale 1ns / 1ps
// tb_handheld_bus_decoder_mbc1: self-checking bench for the bus decoder with mbc1 bank control
// depends on hbd_pkg and handheld_bus_decoder_mbc1; decodes are predicted in-bench and
// compared beat by beat under several cart settings and idle patterns

module tb_handheld_bus_decoder_mbc1;
  import hbd_pkg::*;

  localparam int STALL_LIMIT = 2000;  // cycles with no beat on any channel
  localparam int HOLD_CYCLES = 80;    // long receiver hold-off
  localparam int MAX_PRINTS  = 50;
  localparam int RAND_PHASES = 6;
  localparam int PHASE_ITEMS = 75;
  localparam logic [ROM_BANK_MAX_W-1:0] BANK_MASK = ROM_BANK_MAX_W'((1 << ROM_BANK_BITS_DEF) - 1);

  typedef enum logic [1:0] {IDLE_OFF, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  // every input known from time zero
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  acc_valid = 1'b0;
  logic                  acc_stall;
  access_t               acc_beat  = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  result_t               res_beat;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  handheld_bus_decoder_mbc1 uut (
    .clk          (clk),
    .rst          (rst),
    .access_valid (acc_valid),
    .access_stall (acc_stall),
    .access       (acc_beat),
    .result_valid (res_valid),
    .result_stall (res_stall),
    .result       (res_beat),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // accesses waiting to be driven, decodes waiting to come back
  access_t    pending_accesses[$];
  result_t    pending_decodes[$];
  idle_mode_e idle_mode = IDLE_OFF;
  int         hold_req  = 0;
  int         errors    = 0;

  // predicted config and bank controller state
  logic [1:0]                cart_kind_cfg = CART_NONE;
  logic                      overlay_cfg   = 1'b0;
  logic [ROM_BANK_MAX_W-1:0] bank_rom      = ROM_BANK_MAX_W'(1);
  logic [1:0]                bank_ram      = '0;
  logic                      ram_on        = 1'b0;
  logic                      mode_ram      = 1'b0;

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (errors < MAX_PRINTS) begin
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    end
    errors++;
  endtask

  // maps one access, updating the bank registers on controller writes
  function automatic result_t predict_decode(access_t acc);
    result_t     r;
    logic [15:0] a;
    logic [7:0]  v;
    logic        overlay;
    a = acc.address;
    v = acc.write_data;
    r = '0;
    if (acc.func == FUNC_WRITE && !a[15]) begin
      // controller write: bank state moves, nothing is stored
      if (cart_kind_cfg != CART_NONE) begin
        case (a[14:13])
          SEL_RAM_EN: ram_on = (v == RAM_EN_KEY);
          SEL_ROM_LO: begin
            // low bank bits of zero select bank one
            bank_rom = {bank_rom[6:5], (v[4:0] == 5'd0) ? 5'd1 : v[4:0]} & BANK_MASK;
          end
          SEL_ROM_HI: begin
            if (mode_ram) bank_ram = v[1:0];
            else bank_rom = {v[1:0], bank_rom[4:0]} & BANK_MASK;
          end
          SEL_MODE: begin
            // mode only exists on carts with ram
            if (cart_kind_cfg == CART_MBC1_RAM || cart_kind_cfg == CART_MBC1_RAM_BATT)
              mode_ram = v[0];
          end
        endcase
      end
      r.region      = REGION_MBC;
      r.phys_offset = OFFSET_W'(a);
    end else begin
      // boot overlay applies to reads only
      overlay = (acc.func == FUNC_READ) && overlay_cfg;
      if (a < 16'h4000) begin
        if (overlay && a < 16'h0100) begin
          if (a >= 16'h00D8 && a < 16'h00E0) begin
            r.region = REGION_ICON; r.phys_offset = OFFSET_W'(a - 16'h00D8);
          end else begin
            r.region = REGION_BOOT; r.phys_offset = OFFSET_W'(a);
          end
        end else if (overlay && a >= 16'h0104 && a <= 16'h0133) begin
          r.region = REGION_LOGO; r.phys_offset = OFFSET_W'(a - 16'h0104);
        end else begin
          r.region = REGION_ROM; r.phys_offset = OFFSET_W'(a);
        end
      end else if (a < 16'h8000) begin
        r.region = REGION_ROM; r.phys_offset = {bank_rom & BANK_MASK, a[13:0]};
      end else if (a < 16'hA000) begin
        r.region = REGION_VRAM; r.phys_offset = OFFSET_W'(a[12:0]);
      end else if (a < 16'hC000) begin
        // decoded even while ram is disabled
        r.region = REGION_EXTRAM; r.phys_offset = OFFSET_W'({bank_ram, a[12:0]});
      end else if (a < 16'hFE00) begin
        r.region = REGION_WRAM; r.phys_offset = OFFSET_W'(a[12:0]);
      end else if (a < 16'hFEA0) begin
        r.region = REGION_OAM; r.phys_offset = OFFSET_W'(a[7:0]);
      end else if (a < 16'hFF00) begin
        r.region = REGION_NONE;  // unusable hole, offset zero
      end else if (a == 16'hFFFF) begin
        r.region = REGION_IE;
      end else if (a >= 16'hFF80) begin
        r.region = REGION_HRAM; r.phys_offset = OFFSET_W'(a[6:0]);
      end else begin
        r.region = REGION_IO; r.phys_offset = OFFSET_W'(a[7:0]);
      end
    end
    r.ram_enabled      = ram_on;
    r.current_rom_bank = bank_rom;
    r.current_ram_bank = bank_ram;
    return r;
  endfunction

  // random idle decision for either side
  function automatic logic side_idle(logic is_sender);
    case (idle_mode)
      IDLE_SENDER:   return is_sender && $urandom_range(99) < 64;
      IDLE_RECEIVER: return !is_sender && $urandom_range(99) < 64;
      IDLE_BOTH:     return $urandom_range(99) < 8;
      default:       return 1'b0;
    endcase
  endfunction

  // driver: offers the next access, holds a stalled beat unchanged
  always @(posedge clk) begin
    if (rst) begin
      acc_valid <= 1'b0;
    end else begin
      if (acc_valid && !acc_stall) pending_decodes.push_back(predict_decode(acc_beat));
      if (!acc_valid || !acc_stall) begin
        if (pending_accesses.size() > 0 && !side_idle(1'b1)) begin
          acc_beat  <= pending_accesses.pop_front();
          acc_valid <= 1'b1;
        end else begin
          acc_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result beat and drives the receiver stall
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      res_stall <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        if (pending_decodes.size() == 0) begin
          report_mismatch("result beat with nothing pending, region",
                          32'(res_beat.region), 0);
        end else begin
          want = pending_decodes.pop_front();
          if (res_beat.region != want.region)
            report_mismatch("region", 32'(res_beat.region), 32'(want.region));
          if (res_beat.phys_offset != want.phys_offset)
            report_mismatch("phys_offset", 32'(res_beat.phys_offset),
                            32'(want.phys_offset));
          if (res_beat.ram_enabled != want.ram_enabled)
            report_mismatch("ram_enabled", 32'(res_beat.ram_enabled),
                            32'(want.ram_enabled));
          if (res_beat.current_rom_bank != want.current_rom_bank)
            report_mismatch("current_rom_bank", 32'(res_beat.current_rom_bank),
                            32'(want.current_rom_bank));
          if (res_beat.current_ram_bank != want.current_ram_bank)
            report_mismatch("current_ram_bank", 32'(res_beat.current_ram_bank),
                            32'(want.current_ram_bank));
        end
      end
      // long hold-off once requested, so the block backs up into its input
      if (hold_req != hold_seen && res_valid) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        res_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        res_stall <= 1'b1;
      end else begin
        res_stall <= side_idle(1'b0);
      end
    end
  end

  // watchdog: ends the run when no channel moves for too long
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((acc_valid && !acc_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_handheld_bus_decoder_mbc1 failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // config write, only issued while nothing is in flight
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_CART_KIND:    cart_kind_cfg = val;
      CFG_BOOT_OVERLAY: overlay_cfg   = val[0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (pending_accesses.size() > 0 || acc_valid || pending_decodes.size() > 0)
      @(posedge clk);
  endtask

  function automatic access_t beat(logic f, logic [15:0] a, logic [7:0] d);
    access_t acc;
    acc.func       = f;
    acc.address    = a;
    acc.write_data = d;
    return acc;
  endfunction

  // mix of controller writes, overlay window reads and banked window and high area accesses
  function automatic access_t random_access();
    access_t acc;
    acc.func       = 1'($urandom_range(1));
    acc.address    = 16'($urandom);
    acc.write_data = 8'($urandom);
    case ($urandom_range(9))
      0, 1, 2: begin
        acc.func       = FUNC_WRITE;
        acc.address[15] = 1'b0;
        case ($urandom_range(3))
          0: acc.write_data = RAM_EN_KEY;
          1: acc.write_data[4:0] = 5'd0;
          default: ;
        endcase
      end
      3: begin
        acc.func    = FUNC_READ;
        acc.address = {7'd0, acc.address[8:0]};  // overlay windows
      end
      4: acc.address[15:14] = 2'b01;    // switched rom bank
      5: acc.address[15:13] = 3'b101;   // external ram
      6: acc.address[15:9]  = 7'h7F;    // oam, hole, io, hram, ie
      default: ;
    endcase
    return acc;
  endfunction

  initial begin
    logic [1:0] cart_plan[RAND_PHASES];
    logic       boot_plan[RAND_PHASES];
    idle_mode_e idle_plan[RAND_PHASES];
    cart_plan = '{CART_NONE, CART_MBC1, CART_MBC1_RAM_BATT, CART_MBC1_RAM,
                  CART_MBC1_RAM_BATT, CART_MBC1};
    boot_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    idle_plan = '{IDLE_OFF, IDLE_OFF, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_SENDER};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: overlay windows, each controller register, region edges
    write_reg(CFG_CART_KIND, CART_MBC1_RAM);
    write_reg(CFG_BOOT_OVERLAY, 2'd1);
    pending_accesses.push_back(beat(FUNC_READ,  16'h00D8, 8'h00));  // icon start
    pending_accesses.push_back(beat(FUNC_READ,  16'h00DF, 8'hFF));  // icon end
    pending_accesses.push_back(beat(FUNC_READ,  16'h00FF, 8'h00));  // boot
    pending_accesses.push_back(beat(FUNC_READ,  16'h0104, 8'h00));  // logo start
    pending_accesses.push_back(beat(FUNC_READ,  16'h0133, 8'h00));  // logo end
    pending_accesses.push_back(beat(FUNC_READ,  16'h3FFF, 8'h00));  // rom bank 0
    pending_accesses.push_back(beat(FUNC_WRITE, 16'h0000, 8'h0A));  // ram enable key
    pending_accesses.push_back(beat(FUNC_WRITE, 16'h2000, 8'h00));  // bank zero maps to one
    pending_accesses.push_back(beat(FUNC_WRITE, 16'h3FFF, 8'hFF));  // low bits all set
    pending_accesses.push_back(beat(FUNC_WRITE, 16'h4000, 8'h03));  // upper rom bits
    pending_accesses.push_back(beat(FUNC_READ,  16'h7FFF, 8'h00));  // top of bank 0x7f
    pending_accesses.push_back(beat(FUNC_WRITE, 16'h6000, 8'h01));  // ram banking mode
    pending_accesses.push_back(beat(FUNC_WRITE, 16'h5FFF, 8'hFE));  // ram bank 2
    pending_accesses.push_back(beat(FUNC_READ,  16'hBFFF, 8'h00));  // banked ext ram
    pending_accesses.push_back(beat(FUNC_WRITE, 16'h1FFF, 8'h0B));  // not the key, disable
    pending_accesses.push_back(beat(FUNC_READ,  16'hA000, 8'h00));  // ext ram while disabled
    pending_accesses.push_back(beat(FUNC_READ,  16'h9FFF, 8'h00));  // vram end
    pending_accesses.push_back(beat(FUNC_READ,  16'hE000, 8'h00));  // wram shadow
    pending_accesses.push_back(beat(FUNC_READ,  16'hFE9F, 8'h00));  // oam end
    pending_accesses.push_back(beat(FUNC_READ,  16'hFEA0, 8'h00));  // unusable hole
    pending_accesses.push_back(beat(FUNC_READ,  16'hFF7F, 8'h00));  // io end
    pending_accesses.push_back(beat(FUNC_READ,  16'hFF80, 8'h00));  // hram start
    pending_accesses.push_back(beat(FUNC_READ,  16'hFFFF, 8'h00));  // ie
    pending_accesses.push_back(beat(FUNC_WRITE, 16'h00D8, 8'h55));  // low write skips overlay
    pending_accesses.push_back(beat(FUNC_WRITE, 16'hFFFE, 8'hAA));  // high write decodes
    pending_accesses.push_back(beat(FUNC_WRITE, 16'h7FFF, 8'h00));  // back to rom mode
    wait_drained();

    // random phases, one setting each
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_reg(CFG_CART_KIND, cart_plan[p]);
      write_reg(CFG_BOOT_OVERLAY, {1'b0, boot_plan[p]});
      idle_mode <= idle_plan[p];
      if (p == 1) hold_req <= hold_req + 1;  // sender keeps offering under the hold
      repeat (PHASE_ITEMS) pending_accesses.push_back(random_access());
      wait_drained();
    end

    // let any stray beat show up
    idle_mode <= IDLE_OFF;
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_handheld_bus_decoder_mbc1 passed");
    end else begin
      $display("tb_handheld_bus_decoder_mbc1 failed");
    end
    $finish;
  end

endmodule
